@@ rtl/ucds_pkg.sv @@
// Types and constants shared by the configuration descriptor scanner.
package ucds_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } ucds_req_type;

   typedef struct packed {
      logic [1:0]  scan_status;
      logic [7:0]  interface_number;
      logic [7:0]  endpoint_address;
      logic [6:0]  packet_size;
      logic [15:0] report_length;
   } ucds_rsp_type;

   localparam logic [1:0] StatusFound       = 2'd0;
   localparam logic [1:0] StatusMalformed   = 2'd1;
   localparam logic [1:0] StatusUnsupported = 2'd2;

   localparam logic [1:0] ModeGamepad  = 2'd0;
   localparam logic [1:0] ModeXinput   = 2'd1;
   localparam logic [1:0] ModeKeyboard = 2'd2;

   localparam logic [7:0] DescInterface = 8'h04;
   localparam logic [7:0] DescEndpoint  = 8'h05;
   localparam logic [7:0] DescHid       = 8'h21;
   localparam logic [7:0] DescReport    = 8'h22;

   localparam logic [7:0] ClassHid       = 8'h03;
   localparam logic [7:0] ClassVendor    = 8'hff;
   localparam logic [7:0] SubclassXinput = 8'h5d;
   localparam logic [7:0] SubclassBoot   = 8'h01;
   localparam logic [7:0] ProtocolNone   = 8'h00;
   localparam logic [7:0] ProtocolOne    = 8'h01;

   localparam logic [7:0] IfaceMinLength = 8'd9;
   localparam logic [7:0] EpMinLength    = 8'd7;
   localparam logic [7:0] DescMinLength  = 8'd2;

endpackage

@@ rtl/usb_config_descriptor_scan.sv @@
// Top level of the streaming USB configuration descriptor scanner.
//
// Usage: a configuration descriptor enters on the req_ channel one byte per
// request, with last_byte set on the final byte. The scanner reads the total
// length from bytes 2-3, walks the chained descriptors, and picks the
// interface, interrupt IN endpoint and (gamepad mode) report length for the
// class set by csr_wr_data (written with csr_wr_en while the scanner is idle).
// Only the request carrying last_byte produces a response on the rsp_
// channel: status plus the found fields, zero unless the status is found.
// The response is registered: it is valid in the cycle after the last byte is taken.
// Throughput: one byte per cycle; each byte is a single state update between
// the scan registers and the response register.
// The response register holds a finished result while the next descriptor's
// bytes are already accepted; req_ready drops only for a last byte while
// that register is full and rsp_ready is low.
// Reset (synchronous): clears scan state, the response valid and the mode
// (gamepad). After each last byte the scan state returns to its reset value.
module usb_config_descriptor_scan #(
   parameter int MAX_PACKET        = 64,
   parameter int MAX_REPORT_LENGTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ucds_pkg::ucds_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ucds_pkg::ucds_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [1:0]             csr_wr_data
);
   import ucds_pkg::*;

   localparam logic [15:0] MaxPacketW = 16'(MAX_PACKET);
   localparam logic [15:0] MaxReportW = 16'(MAX_REPORT_LENGTH);

   logic [1:0]   mode_ff;
   logic [15:0]  pos_ff, pos_in;
   logic [15:0]  total_ff, total_in;
   logic [7:0]   dlen_ff, dlen_in;
   logic [7:0]   dtype_ff, dtype_in;
   logic [7:0]   doff_ff, doff_in;
   logic [7:0]   cap_ff [8];
   logic [7:0]   cap_in [8];
   logic         cand_ff, cand_in;
   logic         stop_ff, stop_in;
   logic         err_ff, err_in;
   logic [7:0]   fif_ff, fif_in;
   logic [7:0]   fep_ff, fep_in;
   logic [6:0]   fpkt_ff, fpkt_in;
   logic [15:0]  frep_ff, frep_in;
   logic [7:0]   head_ff, head_in;
   logic [1:0]   phase_ff, phase_in;
   logic [7:0]   group_ff, group_in;
   logic         rsp_valid_ff, rsp_valid_in;
   ucds_rsp_type rsp_ff, rsp_in;

   logic         req_fire;
   logic [7:0]   b;
   logic [15:0]  total_eff;
   logic         check_en;
   logic         go;
   logic [7:0]   n;
   logic [7:0]   typ;
   logic         match;
   logic [15:0]  ep_size;
   logic         short_input;
   logic         ok;
   logic [1:0]   status;

   assign req_ready = !rsp_valid_ff || rsp_ready || !req_data.last_byte;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign b         = req_data.data_byte;

   always_comb begin
      pos_in       = pos_ff;
      total_in     = total_ff;
      dlen_in      = dlen_ff;
      dtype_in     = dtype_ff;
      doff_in      = doff_ff;
      cap_in       = cap_ff;
      cand_in      = cand_ff;
      stop_in      = stop_ff;
      err_in       = err_ff;
      fif_in       = fif_ff;
      fep_in       = fep_ff;
      fpkt_in      = fpkt_ff;
      frep_in      = frep_ff;
      head_in      = head_ff;
      phase_in     = phase_ff;
      group_in     = group_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      go           = 1'b0;
      match        = 1'b0;
      short_input  = 1'b0;
      ok           = 1'b0;
      status       = StatusMalformed;
      ep_size      = {b, cap_ff[4]};
      n            = (doff_ff == 8'd0) ? b : dlen_ff;
      typ          = (doff_ff == 8'd1) ? b : dtype_ff;
      check_en     = pos_ff >= 16'd3;

      if (pos_ff == 16'd2) begin
         total_eff = {8'd0, b};
      end else if (pos_ff == 16'd3) begin
         total_eff = {b, total_ff[7:0]};
      end else begin
         total_eff = total_ff;
      end

      if (req_fire) begin
         total_in = total_eff;
         if (pos_ff == 16'd0) begin
            head_in = b;
         end

         // descriptor walk; bytes 0-2 are walked with the length checks held back
         if (!stop_ff && !err_ff) begin
            go = 1'b1;
            if (doff_ff == 8'd0) begin
               if (check_en && ({1'b0, pos_ff} + 17'd2 > {1'b0, total_eff})) begin
                  stop_in = 1'b1;
                  go      = 1'b0;
               end else begin
                  dlen_in = b;
                  if (check_en && (b < DescMinLength ||
                                   {8'd0, b} > total_eff - pos_ff)) begin
                     err_in = 1'b1;
                     go     = 1'b0;
                  end
               end
            end
            if (go && doff_ff < 8'd8) begin
               cap_in[doff_ff[2:0]] = b;
            end
            if (go && doff_ff == 8'd1) begin
               dtype_in = b;
               if (b == DescInterface && n >= IfaceMinLength && fep_ff != 8'd0 &&
                   (mode_ff inside {ModeXinput, ModeKeyboard} || frep_ff != 16'd0)) begin
                  stop_in = 1'b1;
                  go      = 1'b0;
               end
            end
            if (go) begin
               if (typ == DescInterface && n >= IfaceMinLength && doff_ff == 8'd7) begin
                  case (mode_ff)
                     ModeGamepad:  match = cap_ff[3] == 8'd0 && cap_ff[5] == ClassHid &&
                                           b == ProtocolNone;
                     ModeXinput:   match = cap_ff[3] == 8'd0 && cap_ff[5] == ClassVendor &&
                                           cap_ff[6] == SubclassXinput && b == ProtocolOne;
                     ModeKeyboard: match = cap_ff[5] == ClassHid &&
                                           cap_ff[6] == SubclassBoot && b == ProtocolOne;
                     default:      match = 1'b0;
                  endcase
                  cand_in = match;
                  if (match) begin
                     fif_in = cap_ff[2];
                     if (mode_ff != ModeKeyboard) begin
                        fep_in  = 8'd0;
                        fpkt_in = 7'd0;
                        frep_in = 16'd0;
                     end
                  end
               end else if (cand_ff && mode_ff == ModeGamepad && typ == DescHid &&
                            n >= IfaceMinLength && doff_ff >= 8'd6) begin
                  case (phase_ff)
                     2'd0: cap_in[6] = b;
                     2'd1: cap_in[7] = b;
                     default: begin
                        if (group_ff < cap_ff[5] && cap_ff[6] == DescReport) begin
                           frep_in = {b, cap_ff[7]};
                        end
                     end
                  endcase
               end else if (cand_ff && typ == DescEndpoint && n >= EpMinLength &&
                            doff_ff == 8'd5) begin
                  if (cap_ff[2][7] && cap_ff[3][1:0] == 2'b11 &&
                      ep_size != 16'd0 && ep_size <= MaxPacketW) begin
                     fep_in  = cap_ff[2];
                     fpkt_in = ep_size[6:0];
                  end
               end

               if ({1'b0, doff_ff} + 9'd1 >= {1'b0, n}) begin
                  doff_in  = 8'd0;
                  phase_in = 2'd0;
                  group_in = 8'd0;
               end else begin
                  doff_in = doff_ff + 8'd1;
                  if (doff_ff <= 8'd5) begin
                     phase_in = 2'd0;
                     group_in = 8'd0;
                  end else if (phase_ff == 2'd2) begin
                     phase_in = 2'd0;
                     group_in = group_ff + 8'd1;
                  end else begin
                     phase_in = phase_ff + 2'd1;
                  end
               end
            end
         end

         // held-back checks for descriptors starting at bytes 0 and 2
         if (pos_ff == 16'd3) begin
            if (total_eff < 16'd2) begin
               stop_in = 1'b1;
               err_in  = 1'b0;
            end else if (head_ff < DescMinLength || {8'd0, head_ff} > total_eff) begin
               stop_in = 1'b0;
               err_in  = 1'b1;
            end else if (head_ff == DescMinLength) begin
               if (total_eff < 16'd4) begin
                  stop_in = 1'b1;
                  err_in  = 1'b0;
               end else if (total_ff[7:0] < DescMinLength ||
                            {8'd0, total_ff[7:0]} > total_eff - 16'd2) begin
                  stop_in = 1'b0;
                  err_in  = 1'b1;
               end
            end
         end

         if (pos_ff != 16'hffff) begin
            pos_in = pos_ff + 16'd1;
         end

         if (req_data.last_byte) begin
            short_input = pos_ff < 16'd3 || ({1'b0, pos_ff} + 17'd1 < {1'b0, total_eff});
            ok = fep_in != 8'd0 && mode_ff <= ModeKeyboard;
            if (mode_ff == ModeGamepad) begin
               ok = ok && frep_in != 16'd0 && frep_in <= MaxReportW;
            end
            if (err_in || short_input) begin
               status = StatusMalformed;
            end else if (ok) begin
               status = StatusFound;
            end else begin
               status = StatusUnsupported;
            end
            rsp_in.scan_status = status;
            if (status == StatusFound) begin
               rsp_in.interface_number = fif_in;
               rsp_in.endpoint_address = fep_in;
               rsp_in.packet_size      = fpkt_in;
               rsp_in.report_length    = (mode_ff == ModeGamepad) ? frep_in : 16'd0;
            end else begin
               rsp_in.interface_number = 8'd0;
               rsp_in.endpoint_address = 8'd0;
               rsp_in.packet_size      = 7'd0;
               rsp_in.report_length    = 16'd0;
            end
            rsp_valid_in = 1'b1;

            pos_in   = 16'd0;
            total_in = 16'd0;
            dlen_in  = 8'd0;
            dtype_in = 8'd0;
            doff_in  = 8'd0;
            cand_in  = 1'b0;
            stop_in  = 1'b0;
            err_in   = 1'b0;
            fif_in   = 8'd0;
            fep_in   = 8'd0;
            fpkt_in  = 7'd0;
            frep_in  = 16'd0;
            head_in  = 8'd0;
            phase_in = 2'd0;
            group_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ModeGamepad;
         pos_ff       <= 16'd0;
         total_ff     <= 16'd0;
         dlen_ff      <= 8'd0;
         dtype_ff     <= 8'd0;
         doff_ff      <= 8'd0;
         cand_ff      <= 1'b0;
         stop_ff      <= 1'b0;
         err_ff       <= 1'b0;
         fif_ff       <= 8'd0;
         fep_ff       <= 8'd0;
         fpkt_ff      <= 7'd0;
         frep_ff      <= 16'd0;
         head_ff      <= 8'd0;
         phase_ff     <= 2'd0;
         group_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         pos_ff       <= pos_in;
         total_ff     <= total_in;
         dlen_ff      <= dlen_in;
         dtype_ff     <= dtype_in;
         doff_ff      <= doff_in;
         cand_ff      <= cand_in;
         stop_ff      <= stop_in;
         err_ff       <= err_in;
         fif_ff       <= fif_in;
         fep_ff       <= fep_in;
         fpkt_ff      <= fpkt_in;
         frep_ff      <= frep_in;
         head_ff      <= head_in;
         phase_ff     <= phase_in;
         group_ff     <= group_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff <= cap_in;
      rsp_ff <= rsp_in;
   end

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last_byte) |=> rsp_valid)
      else $error("last byte produced no response");

   a_last_clears_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last_byte) |=>
         (pos_ff == 16'd0 && !stop_ff && !err_ff && fep_ff == 8'd0))
      else $error("scan state not cleared after last byte");

   a_fail_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.scan_status != StatusFound) |->
         (rsp_data.interface_number == 8'd0 && rsp_data.endpoint_address == 8'd0 &&
          rsp_data.packet_size == 7'd0 && rsp_data.report_length == 16'd0))
      else $error("failed scan reports nonzero fields");

   a_stop_err_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(stop_ff && err_ff))
      else $error("walk both stopped and in error");

endmodule
